// ===== rtl/gah_pkg.sv =====
// Shared types and constants for the generational handle allocator.
package gah_pkg;

   localparam int SLOTS = 64;
   localparam int Pools = 2;
   localparam int SlotW = $clog2(SLOTS);
   localparam int CntW  = $clog2(SLOTS + 1);
   localparam int GenW  = 32;
   localparam int AddrW = SlotW + 1;

   typedef enum logic [1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_FREE   = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      func_type          func;
      logic              pool;
      logic              handle_kind;
      logic [SlotW-1:0]  slot_id;
      logic [GenW-1:0]   handle_gen;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SlotW-1:0]  out_slot;
      logic [GenW-1:0]   out_gen;
   } rsp_type;

   // free stack entry keeps the generation the slot had when it was pushed
   typedef struct packed {
      logic [SlotW-1:0]  slot;
      logic [GenW-1:0]   gen;
   } stk_entry_type;

   typedef struct packed {
      logic              en;
      logic [AddrW-1:0]  addr;
      logic [GenW-1:0]   data;
   } gen_wr_type;

   typedef struct packed {
      logic              en;
      logic [AddrW-1:0]  addr;
      stk_entry_type     data;
   } stk_wr_type;

endpackage

// ===== rtl/gah_ram.sv =====
// Generic single write port, single registered read port RAM.
module gah_ram #(
   parameter int AW = 7,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gah_core.sv =====
// Per-pool counters and the single-pass allocate / lookup / free decision.
module gah_core import gah_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                commit,
   input  req_type             item,
   input  logic [GenW-1:0]     gen_val,
   input  stk_entry_type       stk_val,
   input  logic                rd_pool,
   output rsp_type             result,
   output gen_wr_type          gen_wr,
   output stk_wr_type          stk_wr,
   output logic [AddrW-1:0]    stk_raddr
);

   logic [CntW-1:0] depth_ff [Pools];
   logic [CntW-1:0] depth_in [Pools];
   logic [CntW-1:0] count_ff [Pools];
   logic [CntW-1:0] count_in [Pools];

   logic            p;
   logic [CntW-1:0] depth;
   logic [CntW-1:0] count;
   logic [GenW-1:0] gen_up;
   logic [GenW-1:0] pop_gen;
   logic            hit;
   logic            do_pop;
   logic            do_new;
   logic            do_push;
   logic [CntW-1:0] top_idx;

   always_comb begin
      p       = item.pool;
      depth   = depth_ff[p];
      count   = count_ff[p];
      gen_up  = gen_val + GenW'(1);
      pop_gen = stk_val.gen + GenW'(1);
      hit     = (item.handle_kind == p) && (CntW'(item.slot_id) < count)
                && (gen_val == item.handle_gen);
      do_pop  = 1'b0;
      do_new  = 1'b0;
      do_push = 1'b0;
      result  = '{status: STATUS_BAD, out_slot: '0, out_gen: '0};
      gen_wr  = '0;
      stk_wr  = '0;

      unique case (item.func)
         FUNC_ALLOC: begin
            if (depth != '0) begin
               do_pop = 1'b1;
               result = '{status: STATUS_OK, out_slot: stk_val.slot, out_gen: pop_gen};
            end else if (count != CntW'(SLOTS)) begin
               do_new = 1'b1;
               result = '{status: STATUS_OK, out_slot: count[SlotW-1:0],
                          out_gen: GenW'(1)};
            end else begin
               result = '{status: STATUS_FULL, out_slot: '0, out_gen: '0};
            end
         end
         FUNC_LOOKUP, FUNC_FREE: begin
            if (!hit) begin
               result = '{status: STATUS_BAD, out_slot: item.slot_id, out_gen: '0};
            end else if (item.func == FUNC_FREE && gen_val[0]
                         && depth != CntW'(SLOTS)) begin
               // odd generation means live: push it and make it even
               do_push = 1'b1;
               result  = '{status: STATUS_OK, out_slot: item.slot_id, out_gen: gen_up};
            end else begin
               result = '{status: STATUS_OK, out_slot: item.slot_id, out_gen: gen_val};
            end
         end
         FUNC_RSVD: begin
            result = '{status: STATUS_BAD, out_slot: '0, out_gen: '0};
         end
         default: begin
            result = '{status: STATUS_BAD, out_slot: '0, out_gen: '0};
         end
      endcase

      gen_wr.en   = commit && (do_pop || do_new || do_push);
      gen_wr.addr = {p, result.out_slot};
      gen_wr.data = result.out_gen;

      stk_wr.en        = commit && do_push;
      stk_wr.addr      = {p, depth[SlotW-1:0]};
      stk_wr.data.slot = item.slot_id;
      stk_wr.data.gen  = gen_up;

      depth_in = depth_ff;
      count_in = count_ff;
      if (commit) begin
         if (do_pop) begin
            depth_in[p] = depth - CntW'(1);
         end
         if (do_push) begin
            depth_in[p] = depth + CntW'(1);
         end
         if (do_new) begin
            count_in[p] = count + CntW'(1);
         end
      end

      // stack top for the incoming word, seen after this cycle's update
      top_idx   = depth_in[rd_pool] - CntW'(1);
      stk_raddr = {rd_pool, top_idx[SlotW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '{default: '0};
         count_ff <= '{default: '0};
      end else begin
         depth_ff <= depth_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/generational_handle_allocator_top.sv =====
// Generational handle allocator: two slot pools with free stacks and generations.
//
// Request channel (req_valid / req_stall / req_data): one word per operation,
// allocate, lookup or free, against the buffer pool or the image pool.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one word per
// request, in request order, carrying status, slot and current generation.
// A request is registered into the working stage at accept, and its response
// word at commit. Throughput is one request per cycle while the receiver
// does not stall; the generation RAM and free stack RAM are read at accept,
// written at commit, with a one-entry bypass for the read-modify-write turnaround.
// When the receiver stalls, the response register holds its word and one
// more request can still sit in the working stage; further requests are
// stalled until the response is taken.
// Reset (synchronous, active high) empties both pools: free stacks and
// slot counts go to zero. RAM contents are not cleared; only entries below
// the slot count or stack depth are ever used.
module generational_handle_allocator_top import gah_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             accept;
   logic             commit;
   logic             out_free;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_type          s1_ff;
   logic [AddrW-1:0] stk_addr_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;

   gen_wr_type       gen_wr;
   stk_wr_type       stk_wr;
   gen_wr_type       gen_fwd_ff;
   gen_wr_type       gen_fwd_in;
   stk_wr_type       stk_fwd_ff;
   stk_wr_type       stk_fwd_in;

   logic [GenW-1:0]  gen_rd;
   logic [$bits(stk_entry_type)-1:0] stk_rd;
   logic [GenW-1:0]  gen_val;
   stk_entry_type    stk_val;
   logic [AddrW-1:0] stk_raddr;
   rsp_type          result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !commit);
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   gah_ram #(
      .AW (AddrW),
      .DW (GenW)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr.en),
      .wr_addr (gen_wr.addr),
      .wr_data (gen_wr.data),
      .rd_en   (accept),
      .rd_addr ({req_data.pool, req_data.slot_id}),
      .rd_data (gen_rd)
   );

   gah_ram #(
      .AW ($bits(stk_raddr)),
      .DW ($bits(stk_entry_type))
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr.en),
      .wr_addr (stk_wr.addr),
      .wr_data (stk_wr.data),
      .rd_en   (accept),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   // last write wins over RAM data that was read on the same edge
   always_comb begin
      gen_val = gen_rd;
      if (gen_fwd_ff.en && gen_fwd_ff.addr == {s1_ff.pool, s1_ff.slot_id}) begin
         gen_val = gen_fwd_ff.data;
      end
      stk_val = stk_entry_type'(stk_rd);
      if (stk_fwd_ff.en && stk_fwd_ff.addr == stk_addr_ff) begin
         stk_val = stk_fwd_ff.data;
      end
      gen_fwd_in = gen_wr.en ? gen_wr : gen_fwd_ff;
      stk_fwd_in = stk_wr.en ? stk_wr : stk_fwd_ff;
   end

   gah_core u_core (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .item      (s1_ff),
      .gen_val   (gen_val),
      .stk_val   (stk_val),
      .rd_pool   (req_data.pool),
      .result    (result),
      .gen_wr    (gen_wr),
      .stk_wr    (stk_wr),
      .stk_raddr (stk_raddr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gen_fwd_ff   <= '0;
         stk_fwd_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_fwd_ff   <= gen_fwd_in;
         stk_fwd_ff   <= stk_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= req_data;
         stk_addr_ff <= stk_raddr;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty working stage");

   a_push_bumps_gen: assert property (@(posedge clock) disable iff (reset)
      stk_wr.en |-> (gen_wr.en && gen_wr.addr[AddrW-1] == stk_wr.addr[AddrW-1]
                     && gen_wr.addr[SlotW-1:0] == stk_wr.data.slot
                     && gen_wr.data == stk_wr.data.gen))
      else $error("free stack push without matching generation update");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed word did not reach the response register");

   a_write_needs_commit: assert property (@(posedge clock) disable iff (reset)
      gen_wr.en |-> commit)
      else $error("generation write outside a commit");

endmodule

// ===== dv/tb.sv =====
// Testbench for generational_handle_allocator_top: directed and random handle traffic vs. a scoreboard.
`timescale 1ns / 100ps

module tb;
   import gah_pkg::*;

   localparam int IdleLimit = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // mirror of the allocator state, per pool
   logic [GenW-1:0]  gen_tbl     [Pools][SLOTS];
   logic [SlotW-1:0] freed_slots [Pools][SLOTS];
   int               freed_cnt   [Pools] = '{0, 0};
   int               made_cnt    [Pools] = '{0, 0};

   rsp_type pending_rsp[$];
   int      errors      = 0;
   int      idle_cycles = 0;
   int      hold_left   = 0;
   int      rx_run      = 0;
   bit      rx_stalling = 1'b0;
   bit      tx_no_gaps  = 1'b0;

   generational_handle_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type mk(func_type f, logic p, logic k, logic [SlotW-1:0] s,
                                  logic [GenW-1:0] g);
      req_type w;
      w.func        = f;
      w.pool        = p;
      w.handle_kind = k;
      w.slot_id     = s;
      w.handle_gen  = g;
      return w;
   endfunction

   // applies one operation to the mirror and returns the word the block should answer
   function automatic rsp_type handle_outcome(req_type w);
      rsp_type          r;
      int               p;
      logic [SlotW-1:0] s;
      p = int'(w.pool);
      s = w.slot_id;
      r.status   = STATUS_OK;
      r.out_slot = '0;
      r.out_gen  = '0;
      case (w.func)
         FUNC_ALLOC: begin
            if (freed_cnt[p] != 0) begin
               freed_cnt[p]--;
               s = freed_slots[p][freed_cnt[p]];
               gen_tbl[p][s] += 1;
               r.out_slot = s;
               r.out_gen  = gen_tbl[p][s];
            end else if (made_cnt[p] < SLOTS) begin
               s = SlotW'(made_cnt[p]);
               made_cnt[p]++;
               gen_tbl[p][s] = GenW'(1);
               r.out_slot = s;
               r.out_gen  = GenW'(1);
            end else begin
               r.status = STATUS_FULL;
            end
         end
         FUNC_RSVD: r.status = STATUS_BAD;
         default: begin
            if (w.handle_kind != w.pool || s >= made_cnt[p] || gen_tbl[p][s] != w.handle_gen) begin
               r.status   = STATUS_BAD;
               r.out_slot = s;
            end else begin
               // free of a slot already freed (even generation) changes nothing
               if (w.func == FUNC_FREE && gen_tbl[p][s][0] && freed_cnt[p] < SLOTS) begin
                  freed_slots[p][freed_cnt[p]] = s;
                  freed_cnt[p]++;
                  gen_tbl[p][s] += 1;
               end
               r.out_slot = s;
               r.out_gen  = gen_tbl[p][s];
            end
         end
      endcase
      return r;
   endfunction

   // a created slot of the pool, live ones preferred; -1 when none exists
   function automatic int live_slot(int p);
      int start;
      int s;
      if (made_cnt[p] == 0) return -1;
      start = $urandom_range(0, made_cnt[p] - 1);
      for (int i = 0; i < made_cnt[p]; i++) begin
         s = (start + i) % made_cnt[p];
         if (gen_tbl[p][s][0]) return s;
      end
      return start;
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (tx_no_gaps || roll < 60) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      pending_rsp = {pending_rsp, handle_outcome(w)};
   endtask

   // receiver: random stall runs, plus a forced hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_run == 0) begin
            if (!rx_stalling && $urandom_range(0, 9) < 7) begin
               rx_stalling = 1'b1;
               rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
            end else begin
               rx_stalling = 1'b0;
               case ($urandom_range(0, 19))
                  0:       rx_run = $urandom_range(100, 250);
                  1, 2, 3: rx_run = $urandom_range(20, 60);
                  default: rx_run = $urandom_range(1, 12);
               endcase
            end
         end
         rx_run--;
         rsp_stall <= rx_stalling;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word %h", $time, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
            end
            if (rsp_data.out_slot !== want.out_slot) begin
               errors++;
               $display("%0t: out_slot expected %0d actual %0d", $time, want.out_slot,
                        rsp_data.out_slot);
            end
            if (rsp_data.out_gen !== want.out_gen) begin
               errors++;
               $display("%0t: out_gen expected %h actual %h", $time, want.out_gen,
                        rsp_data.out_gen);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("[generational_handle_allocator_top] ERROR");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_word(mk(FUNC_LOOKUP, 1'b0, 1'b0, 6'd0, 32'd0));          // empty pool
      send_word(mk(FUNC_ALLOC, 1'b0, 1'b1, 6'd63, 32'hFFFF_FFFF));
      send_word(mk(FUNC_ALLOC, 1'b1, 1'b0, 6'd0, 32'd0));
      send_word(mk(FUNC_LOOKUP, 1'b0, 1'b0, 6'd0, 32'd1));
      send_word(mk(FUNC_LOOKUP, 1'b0, 1'b1, 6'd0, 32'd1));          // kind mismatch
      send_word(mk(FUNC_LOOKUP, 1'b1, 1'b1, 6'd0, 32'd2));          // generation mismatch
      send_word(mk(FUNC_LOOKUP, 1'b0, 1'b0, 6'd63, 32'hFFFF_FFFF)); // beyond count
      send_word(mk(FUNC_FREE, 1'b0, 1'b0, 6'd1, 32'd1));            // beyond count
      send_word(mk(FUNC_FREE, 1'b0, 1'b0, 6'd0, 32'd1));
      send_word(mk(FUNC_FREE, 1'b0, 1'b0, 6'd0, 32'd2));            // already freed
      send_word(mk(FUNC_LOOKUP, 1'b0, 1'b0, 6'd0, 32'd2));
      send_word(mk(FUNC_FREE, 1'b0, 1'b0, 6'd0, 32'd1));            // stale
      send_word(mk(FUNC_ALLOC, 1'b0, 1'b0, 6'd0, 32'd0));           // reuse
      send_word(mk(FUNC_RSVD, 1'b1, 1'b1, 6'd63, 32'hFFFF_FFFF));
      send_word(mk(FUNC_RSVD, 1'b0, 1'b0, 6'd0, 32'd0));
      send_word(mk(FUNC_ALLOC, 1'b1, 1'b1, 6'd0, 32'd0));
      send_word(mk(FUNC_FREE, 1'b1, 1'b1, 6'd1, 32'd1));
      send_word(mk(FUNC_FREE, 1'b1, 1'b1, 6'd0, 32'd1));
      send_word(mk(FUNC_FREE, 1'b1, 1'b0, 6'd0, 32'd2));            // kind mismatch
      send_word(mk(FUNC_ALLOC, 1'b1, 1'b1, 6'd0, 32'd0));           // LIFO order
      send_word(mk(FUNC_ALLOC, 1'b1, 1'b1, 6'd0, 32'd0));
      send_word(mk(FUNC_LOOKUP, 1'b1, 1'b1, 6'd1, 32'd3));
      send_word(mk(FUNC_ALLOC, 1'b1, 1'b1, 6'd0, 32'd0));
   endtask

   task automatic test_pool_full();
      for (int p = 0; p < Pools; p++) begin
         while (!(freed_cnt[p] == 0 && made_cnt[p] == SLOTS))
            send_word(mk(FUNC_ALLOC, 1'(p), 1'($urandom_range(0, 1)),
                         SlotW'($urandom_range(0, 63)), $urandom()));
         repeat (2) send_word(mk(FUNC_ALLOC, 1'(p), 1'(p), 6'd0, 32'd0));
         send_word(mk(FUNC_LOOKUP, 1'(p), 1'(p), 6'd63, gen_tbl[p][63]));
         for (int s = SLOTS - 1; s >= 0; s--)
            if (gen_tbl[p][s][0])
               send_word(mk(FUNC_FREE, 1'(p), 1'(p), SlotW'(s), gen_tbl[p][s]));
         send_word(mk(FUNC_FREE, 1'(p), 1'(p), 6'd63, gen_tbl[p][63]));
         repeat (3) send_word(mk(FUNC_ALLOC, 1'(p), 1'(p), 6'd0, 32'd0));
      end
   endtask

   task automatic test_backpressure();
      int s;
      hold_left = 150;
      for (int i = 0; i < 40; i++) begin
         s = live_slot(i % 2);
         if (i % 3 == 0 || s < 0)
            send_word(mk(FUNC_ALLOC, 1'(i % 2), 1'(i % 2), 6'd0, 32'd0));
         else
            send_word(mk(FUNC_LOOKUP, 1'(i % 2), 1'(i % 2), SlotW'(s),
                         gen_tbl[i % 2][s]));
      end
   endtask

   task automatic test_random_traffic(input int n);
      req_type w;
      int      pick;
      int      s;
      int      p;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) tx_no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         p    = $urandom_range(0, 1);
         s    = live_slot(p);
         w    = mk(FUNC_ALLOC, 1'(p), 1'($urandom_range(0, 1)),
                   SlotW'($urandom_range(0, 63)), $urandom());
         if (pick < 32 || s < 0) begin
            // allocate with junk in the unused fields
         end else if (pick < 62) begin
            w = mk(FUNC_FREE, 1'(p), 1'(p), SlotW'(s), gen_tbl[p][s]);
         end else if (pick < 84) begin
            w = mk(FUNC_LOOKUP, 1'(p), 1'(p), SlotW'(s), gen_tbl[p][s]);
         end else if (pick < 89) begin
            w = mk(pick < 87 ? FUNC_FREE : FUNC_LOOKUP, 1'(p), 1'(p), SlotW'(s),
                   gen_tbl[p][s] - $urandom_range(1, 2));
         end else if (pick < 92) begin
            w = mk(pick < 90 ? FUNC_FREE : FUNC_LOOKUP, 1'(p), !p[0], SlotW'(s),
                   gen_tbl[p][s]);
         end else if (pick < 97) begin
            w.func = func_type'($urandom_range(0, 2));
         end else begin
            w.func = FUNC_RSVD;
         end
         send_word(w);
      end
      tx_no_gaps = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_full();
      test_backpressure();
      test_random_traffic(1600);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("[generational_handle_allocator_top] OK");
      end else begin
         $display("[generational_handle_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== generational_handle_allocator_top.f =====
rtl/gah_pkg.sv
rtl/gah_ram.sv
rtl/gah_core.sv
rtl/generational_handle_allocator_top.sv
dv/tb.sv
